// File: hdl/jdqc_pkg.sv
// Shared constants and register codes for the joystick dead-zone quadratic curve.
// No dependencies; imported by joystick_deadzone_quadratic_curve.
`default_nettype none

package jdqc_pkg;

   localparam int SAMPLE_BITS = 8;
   localparam int DEAD_BITS   = 7;
   localparam int FULL_SCALE  = 1000;
   localparam int OUT_BITS    = 11;
   localparam int Q_BITS      = 10;

   localparam int LVL_BITS      = ((SAMPLE_BITS > DEAD_BITS) ? SAMPLE_BITS : DEAD_BITS) + 2;
   localparam int CSR_DATA_BITS = (SAMPLE_BITS > DEAD_BITS) ? SAMPLE_BITS : DEAD_BITS;
   localparam int CSR_IDX_BITS  = 3;

   localparam int SQ_BITS  = 2 * SAMPLE_BITS;
   localparam int NUM_BITS = SQ_BITS + $clog2(2 * FULL_SCALE + 1);
   localparam int DEN_BITS = SQ_BITS + 1;

   localparam int DIV_STEPS  = 2;
   localparam int DIV_STAGES = Q_BITS / DIV_STEPS;

   localparam logic [CSR_IDX_BITS-1:0] CSR_CENTER = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MIN    = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MAX    = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_DEAD   = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_INVERT = 3'd4;

   localparam logic [SAMPLE_BITS-1:0] CENTER_RESET = SAMPLE_BITS'(127);
   localparam logic [SAMPLE_BITS-1:0] MIN_RESET    = '0;
   localparam logic [SAMPLE_BITS-1:0] MAX_RESET    = SAMPLE_BITS'(255);
   localparam logic [DEAD_BITS-1:0]   DEAD_RESET   = DEAD_BITS'(20);

endpackage

`default_nettype wire

// File: hdl/joystick_deadzone_quadratic_curve.sv
// Top level: joystick dead-zone quadratic response curve, fully pipelined.
// Depends on jdqc_pkg.
//
// Usage:
//   req_valid/req_stall carry one raw sample per beat; rsp_valid/rsp_stall carry one
//   signed drive value (-1000..1000) per beat. A beat moves when valid is high and
//   stall is low. csr_write_en/csr_index/csr_wdata write the center, minimum,
//   maximum, dead-zone half width and invert registers; write only while idle.
//   Throughput: one sample per cycle while the receiver does not stall a result.
//   The path runs through a classify stage, a square stage, a scale stage, five
//   restoring-division stages of two quotient bits each, and an output register.
//   Reset clears all valid bits and loads the register defaults (center 127,
//   minimum 0, maximum 255, half width 20, no invert).
//   While the receiver stalls a valid result, the whole pipeline holds and
//   req_stall is raised; nothing is dropped or repeated.
`default_nettype none

module joystick_deadzone_quadratic_curve (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic [jdqc_pkg::SAMPLE_BITS-1:0]      req_raw_sample,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic signed [jdqc_pkg::OUT_BITS-1:0]       rsp_drive_value,
   input  wire logic                                  csr_write_en,
   input  wire logic [jdqc_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  wire logic [jdqc_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);
   import jdqc_pkg::*;

   typedef enum logic [2:0] {
      K_NEG_FULL,
      K_NEG_QUAD,
      K_POS_QUAD,
      K_ZERO,
      K_POS_FULL
   } kind_type;

   logic [SAMPLE_BITS-1:0] center_ff, min_ff, max_ff;
   logic [DEAD_BITS-1:0]   dead_ff;
   logic                   invert_ff;

   logic adv;

   // stage 1: classify
   logic                   v1_ff;
   kind_type               k1_ff, k1_in;
   logic [SAMPLE_BITS-1:0] d1_ff, d1_in, sp1_ff, sp1_in;
   logic                   inv1_ff;

   // stage 2: square
   logic                   v2_ff;
   kind_type               k2_ff;
   logic [SQ_BITS-1:0]     dsq2_ff, spsq2_ff;
   logic                   inv2_ff;

   // stage 3 and division stages
   logic                   vd_ff   [DIV_STAGES+1];
   kind_type               kd_ff   [DIV_STAGES+1];
   logic                   invd_ff [DIV_STAGES+1];
   logic [NUM_BITS-1:0]    rem_ff  [DIV_STAGES+1];
   logic [DEN_BITS-1:0]    den_ff  [DIV_STAGES+1];
   logic [Q_BITS-1:0]      q_ff    [DIV_STAGES+1];
   logic [NUM_BITS-1:0]    rem_in  [DIV_STAGES];
   logic [Q_BITS-1:0]      q_in    [DIV_STAGES];

   logic                       rsp_valid_ff;
   logic signed [OUT_BITS-1:0] drive_ff, drive_in;

   logic signed [LVL_BITS-1:0] s_x, mn_x, mx_x, lo_x, hi_x, dead_x;

   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_drive_value = drive_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_ff <= CENTER_RESET;
         min_ff    <= MIN_RESET;
         max_ff    <= MAX_RESET;
         dead_ff   <= DEAD_RESET;
         invert_ff <= 1'b0;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_CENTER: center_ff <= csr_wdata[SAMPLE_BITS-1:0];
            CSR_MIN:    min_ff    <= csr_wdata[SAMPLE_BITS-1:0];
            CSR_MAX:    max_ff    <= csr_wdata[SAMPLE_BITS-1:0];
            CSR_DEAD:   dead_ff   <= csr_wdata[DEAD_BITS-1:0];
            CSR_INVERT: invert_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      s_x    = $signed({{(LVL_BITS-SAMPLE_BITS){1'b0}}, req_raw_sample});
      mn_x   = $signed({{(LVL_BITS-SAMPLE_BITS){1'b0}}, min_ff});
      mx_x   = $signed({{(LVL_BITS-SAMPLE_BITS){1'b0}}, max_ff});
      dead_x = $signed({{(LVL_BITS-DEAD_BITS){1'b0}}, dead_ff});
      lo_x   = $signed({{(LVL_BITS-SAMPLE_BITS){1'b0}}, center_ff}) - dead_x;
      hi_x   = $signed({{(LVL_BITS-SAMPLE_BITS){1'b0}}, center_ff}) + dead_x;
      d1_in  = '0;
      sp1_in = SAMPLE_BITS'(1);
      if (s_x < mn_x) begin
         k1_in = K_NEG_FULL;
      end else if (s_x < lo_x) begin
         k1_in  = K_NEG_QUAD;
         d1_in  = SAMPLE_BITS'(lo_x - s_x);
         sp1_in = SAMPLE_BITS'(lo_x - mn_x);
      end else if (s_x > hi_x && s_x <= mx_x) begin
         k1_in  = K_POS_QUAD;
         d1_in  = SAMPLE_BITS'(s_x - hi_x);
         sp1_in = SAMPLE_BITS'(mx_x - hi_x);
      end else if (s_x >= lo_x && s_x <= hi_x) begin
         k1_in = K_ZERO;
      end else begin
         k1_in = K_POS_FULL;
      end
   end

   always_comb begin
      logic [NUM_BITS-1:0] rem_t;
      logic [Q_BITS-1:0]   q_t;
      logic [NUM_BITS:0]   dsh;
      logic [NUM_BITS:0]   trial;
      for (int st = 0; st < DIV_STAGES; st++) begin
         rem_t = rem_ff[st];
         q_t   = q_ff[st];
         for (int j = 0; j < DIV_STEPS; j++) begin
            dsh   = {{(NUM_BITS+1-DEN_BITS){1'b0}}, den_ff[st]}
                    << (Q_BITS - 1 - (st * DIV_STEPS + j));
            trial = {1'b0, rem_t} - dsh;
            if (!trial[NUM_BITS]) begin
               rem_t = trial[NUM_BITS-1:0];
               q_t   = {q_t[Q_BITS-2:0], 1'b1};
            end else begin
               q_t   = {q_t[Q_BITS-2:0], 1'b0};
            end
         end
         rem_in[st] = rem_t;
         q_in[st]   = q_t;
      end
   end

   always_comb begin
      logic signed [OUT_BITS-1:0] v;
      case (kd_ff[DIV_STAGES])
         K_NEG_FULL: v = -$signed(OUT_BITS'(FULL_SCALE));
         K_NEG_QUAD: v = -$signed(OUT_BITS'(q_ff[DIV_STAGES]));
         K_POS_QUAD: v = $signed(OUT_BITS'(q_ff[DIV_STAGES]));
         K_ZERO:     v = '0;
         K_POS_FULL: v = $signed(OUT_BITS'(FULL_SCALE));
         default:    v = '0;
      endcase
      drive_in = invd_ff[DIV_STAGES] ? -v : v;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i <= DIV_STAGES; i++) begin
            vd_ff[i] <= 1'b0;
         end
      end else if (adv) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         vd_ff[0] <= v2_ff;
         for (int i = 0; i < DIV_STAGES; i++) begin
            vd_ff[i+1] <= vd_ff[i];
         end
         rsp_valid_ff <= vd_ff[DIV_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         k1_ff    <= k1_in;
         d1_ff    <= d1_in;
         sp1_ff   <= sp1_in;
         inv1_ff  <= invert_ff;
         k2_ff    <= k1_ff;
         dsq2_ff  <= SQ_BITS'(d1_ff) * SQ_BITS'(d1_ff);
         spsq2_ff <= SQ_BITS'(sp1_ff) * SQ_BITS'(sp1_ff);
         inv2_ff  <= inv1_ff;
         kd_ff[0]   <= k2_ff;
         invd_ff[0] <= inv2_ff;
         rem_ff[0]  <= NUM_BITS'(dsq2_ff) * NUM_BITS'(2 * FULL_SCALE) + NUM_BITS'(spsq2_ff);
         den_ff[0]  <= {spsq2_ff, 1'b0};
         q_ff[0]    <= '0;
         for (int i = 0; i < DIV_STAGES; i++) begin
            kd_ff[i+1]   <= kd_ff[i];
            invd_ff[i+1] <= invd_ff[i];
            den_ff[i+1]  <= den_ff[i];
            rem_ff[i+1]  <= rem_in[i];
            q_ff[i+1]    <= q_in[i];
         end
         drive_ff <= drive_in;
      end
   end

`ifndef SYNTHESIS
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_drive_value <= $signed(OUT_BITS'(FULL_SCALE)) &&
                     rsp_drive_value >= -$signed(OUT_BITS'(FULL_SCALE))))
      else $error("drive value out of range");

   a_quot: assert property (@(posedge clock) disable iff (reset)
      (vd_ff[DIV_STAGES] && (kd_ff[DIV_STAGES] == K_NEG_QUAD ||
                             kd_ff[DIV_STAGES] == K_POS_QUAD))
      |-> (q_ff[DIV_STAGES] <= Q_BITS'(FULL_SCALE)))
      else $error("quotient above full scale");

   a_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled without a blocked result");

   a_zero: assert property (@(posedge clock) disable iff (reset)
      (adv && vd_ff[DIV_STAGES] && kd_ff[DIV_STAGES] == K_ZERO)
      |=> (rsp_valid && rsp_drive_value == '0))
      else $error("dead zone gave nonzero drive");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!adv && vd_ff[0]) |=> vd_ff[0] && $stable(rem_ff[0]))
      else $error("pipeline moved while stalled");
`endif

endmodule

`default_nettype wire
